### rtl/core/tlt_pkg.sv
// Types and constants shared by the tokenizer unit.
package tlt_pkg;

  localparam int TEXT_BYTES = 8;
  localparam int TEXT_W     = 8 * TEXT_BYTES;
  localparam int LINE_W     = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = PTR_W + 1;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  localparam logic [TEXT_W-1:0] KW_INPUT = 64'h0000_0074_7570_6E69;
  localparam logic [TEXT_W-1:0] KW_PRINT = 64'h0000_0074_6E69_7270;
  localparam logic [TEXT_W-1:0] KW_GOTO  = 64'h0000_0000_6F74_6F67;
  localparam logic [TEXT_W-1:0] KW_IF    = 64'h0000_0000_0000_6669;
  localparam logic [TEXT_W-1:0] KW_THEN  = 64'h0000_0000_6E65_6874;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_LABEL = 2'd1,
    MODE_INT   = 2'd2,
    MODE_IDENT = 2'd3
  } scan_mode_t;

  typedef enum logic [3:0] {
    TOK_END     = 4'd0,
    TOK_LT      = 4'd1,
    TOK_PLUS    = 4'd2,
    TOK_EQUAL   = 4'd3,
    TOK_LABEL   = 4'd4,
    TOK_INT     = 4'd5,
    TOK_IDENT   = 4'd6,
    TOK_INPUT   = 4'd7,
    TOK_PRINT   = 4'd8,
    TOK_GOTO    = 4'd9,
    TOK_IF      = 4'd10,
    TOK_THEN    = 4'd11,
    TOK_INVALID = 4'd12
  } token_kind_t;

  typedef struct packed {
    token_kind_t       kind;
    logic [TEXT_W-1:0] text;
    logic [7:0]        len;
    logic              trunc;
    logic [LINE_W-1:0] line;
    logic              last;
  } token_t;

endpackage

### rtl/core/toy_language_tokenizer_unit.sv
// Character-at-a-time tokenizer with a small result queue.
// A token caused by an item is written into the registered result queue when the item is accepted.
// Throughput: one item per cycle while each item yields at most one token and the
// sink keeps up; an item yielding two tokens fills two queue entries at once.
// Input stalls while fewer than two of the four queue entries are free.
// Synchronous active-low reset: idle, line 1, queue empty; the end item restores idle and line 1.
module toy_language_tokenizer_unit
  import tlt_pkg::*;
#(
  parameter int MAX_TEXT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_code,
  input  logic              in_end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_token_kind,
  output logic [TEXT_W-1:0] out_text_bytes,
  output logic [7:0]        out_text_length,
  output logic              out_text_truncated,
  output logic [LINE_W-1:0] out_source_line,
  output logic              out_last_of_run
);

  scan_mode_t        mode_r, mode_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [7:0]        store_r [MAX_TEXT];

  token_t            fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  logic              accept, pop;
  logic              is_alpha, is_digit, is_space, class_hit;
  logic              trunc;
  logic [TEXT_W-1:0] packed_text;
  logic              flush_v, second_v;
  token_t            flush_tok, second_tok, e0, e1;
  logic [1:0]        push_cnt;
  logic              st_we;
  logic [7:0]        st_idx;

  assign in_stall = fill_r > FILL_W'(FIFO_DEPTH - 2);
  assign accept   = in_valid && !in_stall;
  assign out_valid = fill_r != '0;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    is_alpha = (in_char_code >= 8'h61 && in_char_code <= 8'h7A) ||
               (in_char_code >= 8'h41 && in_char_code <= 8'h5A);
    is_digit = in_char_code >= 8'h30 && in_char_code <= 8'h39;
    is_space = in_char_code == CH_SPACE ||
               (in_char_code >= CH_TAB && in_char_code <= CH_CR);
    unique case (mode_r)
      MODE_LABEL: class_hit = is_alpha;
      MODE_INT:   class_hit = is_digit;
      MODE_IDENT: class_hit = is_alpha || is_digit;
      default:    class_hit = 1'b0;
    endcase

    packed_text = '0;
    for (int i = 0; i < MAX_TEXT; i++) begin
      if (8'(i) < count_r) begin
        packed_text[8*i +: 8] = store_r[i];
      end
    end
    trunc = count_r > 8'(MAX_TEXT);

    flush_tok       = '0;
    flush_tok.line  = line_r;
    flush_tok.text  = packed_text;
    flush_tok.len   = count_r;
    flush_tok.trunc = trunc;
    unique case (mode_r)
      MODE_LABEL: flush_tok.kind = TOK_LABEL;
      MODE_INT:   flush_tok.kind = TOK_INT;
      default:    flush_tok.kind = TOK_IDENT;
    endcase
    if (mode_r == MODE_IDENT && !trunc) begin
      if (count_r == 8'd5 && packed_text == KW_INPUT) begin
        flush_tok.kind = TOK_INPUT;
      end else if (count_r == 8'd5 && packed_text == KW_PRINT) begin
        flush_tok.kind = TOK_PRINT;
      end else if (count_r == 8'd4 && packed_text == KW_GOTO) begin
        flush_tok.kind = TOK_GOTO;
      end else if (count_r == 8'd2 && packed_text == KW_IF) begin
        flush_tok.kind = TOK_IF;
      end else if (count_r == 8'd4 && packed_text == KW_THEN) begin
        flush_tok.kind = TOK_THEN;
      end
      if (flush_tok.kind != TOK_IDENT) begin
        flush_tok.text  = '0;
        flush_tok.len   = '0;
        flush_tok.trunc = 1'b0;
      end
    end

    second_tok      = '0;
    second_tok.line = line_r;
    second_tok.kind = TOK_END;
    second_v  = 1'b0;
    flush_v   = 1'b0;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    line_nxt  = line_r;
    st_we     = 1'b0;
    st_idx    = count_r;

    if (in_end_of_input) begin
      flush_v   = mode_r != MODE_IDLE;
      second_v  = 1'b1;
      mode_nxt  = MODE_IDLE;
      count_nxt = '0;
      line_nxt  = LINE_ONE;
    end else if (mode_r != MODE_IDLE && class_hit) begin
      st_we = count_r < 8'(MAX_TEXT);
      if (count_r != 8'hFF) begin
        count_nxt = count_r + 8'd1;
      end
    end else begin
      flush_v   = mode_r != MODE_IDLE;
      mode_nxt  = MODE_IDLE;
      count_nxt = '0;
      if (is_space) begin
        if (in_char_code == CH_NEWLINE && line_r != LINE_MAX) begin
          line_nxt = line_r + LINE_ONE;
        end
      end else if (in_char_code == CH_LT) begin
        second_v        = 1'b1;
        second_tok.kind = TOK_LT;
      end else if (in_char_code == CH_PLUS) begin
        second_v        = 1'b1;
        second_tok.kind = TOK_PLUS;
      end else if (in_char_code == CH_EQUAL) begin
        second_v        = 1'b1;
        second_tok.kind = TOK_EQUAL;
      end else if (in_char_code == CH_COLON) begin
        mode_nxt = MODE_LABEL;
      end else if (is_digit || is_alpha) begin
        mode_nxt  = is_digit ? MODE_INT : MODE_IDENT;
        count_nxt = 8'd1;
        st_we     = 1'b1;
        st_idx    = '0;
      end else begin
        second_v            = 1'b1;
        second_tok.kind     = TOK_INVALID;
        second_tok.text     = TEXT_W'(in_char_code);
        second_tok.len      = 8'd1;
      end
    end

    e0 = flush_v ? flush_tok : second_tok;
    e1 = second_tok;
    e0.last = !(flush_v && second_v);
    e1.last = 1'b1;
    push_cnt = accept ? (2'(flush_v) + 2'(second_v)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      count_r  <= '0;
      line_r   <= LINE_ONE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (accept) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
        line_r  <= line_nxt;
      end
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_cnt);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      fill_r   <= fill_r + FILL_W'(push_cnt) - FILL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TEXT; i++) begin
      if (accept && st_we && st_idx == 8'(i)) begin
        store_r[i] <= in_char_code;
      end
    end
    if (push_cnt != 2'd0) begin
      fifo_r[wr_ptr_r] <= e0;
    end
    if (push_cnt == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= e1;
    end
  end

  assign out_token_kind     = fifo_r[rd_ptr_r].kind;
  assign out_text_bytes     = fifo_r[rd_ptr_r].text;
  assign out_text_length    = fifo_r[rd_ptr_r].len;
  assign out_text_truncated = fifo_r[rd_ptr_r].trunc;
  assign out_source_line    = fifo_r[rd_ptr_r].line;
  assign out_last_of_run    = fifo_r[rd_ptr_r].last;

endmodule
